// ----- sv/grwp_pkg.sv -----
// ----------------------------------------------------------------------------
// Gamma ramp white point package
// Widths, register codes, blackbody table and fixed-point helpers.
// ----------------------------------------------------------------------------
package grwp_pkg;

	localparam int unsigned IDX_W = 12;
	localparam int unsigned LVL_W = 16;
	localparam int unsigned TEMP_W = 14;
	localparam int unsigned GAM_W = 12;
	localparam int unsigned LEN_W = 13;
	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;

	localparam int unsigned LOG_BITS = 16;
	localparam int unsigned DIV_QBITS = 21;
	localparam int unsigned DIV_PER_STAGE = 3;
	localparam int unsigned DIV_STAGES = DIV_QBITS / DIV_PER_STAGE;
	localparam int unsigned EXP_BITS = 16;

	localparam logic [13:0] T_MIN = 14'd1000;
	localparam logic [13:0] T_MAX = 14'd10000;
	localparam logic [6:0] T_STEP = 7'd100;
	localparam logic [6:0] ROM_LAST = 7'd90;
	localparam logic [12:0] ROW_RECIP = 13'd5243;
	localparam int unsigned ROW_SHIFT = 19;
	localparam logic [30:0] WP_RECIP = 31'd1125899907;
	localparam int unsigned WP_SHIFT = 34;
	localparam logic [16:0] P_ONE = 17'h10000;
	localparam logic [15:0] LEVEL_MAX = 16'hFFFF;
	localparam logic [4:0] K_LIMIT = 5'd17;
	localparam logic [4:0] EXP_SHIFT = 5'd14;

	typedef enum logic [2:0] {
		REG_TEMP  = 3'd0,
		REG_GAM_R = 3'd1,
		REG_GAM_G = 3'd2,
		REG_GAM_B = 3'd3,
		REG_LEN   = 3'd4
	} reg_idx_t;

	// One row per 100 K from 1000 K, red/green/blue in units of 1/10000.
	localparam logic [41:0] BB_ROM [0:90] = '{
		{14'd10000, 14'd425, 14'd0}, {14'd10000, 14'd668, 14'd0},
		{14'd10000, 14'd911, 14'd0}, {14'd10000, 14'd1149, 14'd0},
		{14'd10000, 14'd1380, 14'd0}, {14'd10000, 14'd1604, 14'd0},
		{14'd10000, 14'd1819, 14'd0}, {14'd10000, 14'd2024, 14'd0},
		{14'd10000, 14'd2220, 14'd0}, {14'd10000, 14'd2406, 14'd0},
		{14'd10000, 14'd2630, 14'd62}, {14'd10000, 14'd2868, 14'd155},
		{14'd10000, 14'd3102, 14'd261}, {14'd10000, 14'd3334, 14'd379},
		{14'd10000, 14'd3562, 14'd508}, {14'd10000, 14'd3787, 14'd650},
		{14'd10000, 14'd4008, 14'd802}, {14'd10000, 14'd4227, 14'd964},
		{14'd10000, 14'd4442, 14'd1136}, {14'd10000, 14'd4652, 14'd1316},
		{14'd10000, 14'd4859, 14'd1505}, {14'd10000, 14'd5062, 14'd1702},
		{14'd10000, 14'd5262, 14'd1907}, {14'd10000, 14'd5458, 14'd2118},
		{14'd10000, 14'd5650, 14'd2335}, {14'd10000, 14'd5839, 14'd2558},
		{14'd10000, 14'd6023, 14'd2786}, {14'd10000, 14'd6204, 14'd3018},
		{14'd10000, 14'd6382, 14'd3255}, {14'd10000, 14'd6557, 14'd3495},
		{14'd10000, 14'd6727, 14'd3739}, {14'd10000, 14'd6894, 14'd3986},
		{14'd10000, 14'd7058, 14'd4234}, {14'd10000, 14'd7218, 14'd4485},
		{14'd10000, 14'd7375, 14'd4738}, {14'd10000, 14'd7529, 14'd4992},
		{14'd10000, 14'd7679, 14'd5247}, {14'd10000, 14'd7826, 14'd5503},
		{14'd10000, 14'd7970, 14'd5760}, {14'd10000, 14'd8111, 14'd6016},
		{14'd10000, 14'd8250, 14'd6272}, {14'd10000, 14'd8384, 14'd6529},
		{14'd10000, 14'd8517, 14'd6785}, {14'd10000, 14'd8647, 14'd7040},
		{14'd10000, 14'd8773, 14'd7294}, {14'd10000, 14'd8897, 14'd7548},
		{14'd10000, 14'd9019, 14'd7801}, {14'd10000, 14'd9137, 14'd8051},
		{14'd10000, 14'd9254, 14'd8301}, {14'd10000, 14'd9367, 14'd8550},
		{14'd10000, 14'd9478, 14'd8795}, {14'd10000, 14'd9587, 14'd9040},
		{14'd10000, 14'd9694, 14'd9283}, {14'd10000, 14'd9798, 14'd9524},
		{14'd10000, 14'd9900, 14'd9763}, {14'd10000, 14'd10000, 14'd10000},
		{14'd9917, 14'd10014, 14'd10149}, {14'd9696, 14'd9885, 14'd10149},
		{14'd9488, 14'd9761, 14'd10149}, {14'd9290, 14'd9642, 14'd10149},
		{14'd9102, 14'd9529, 14'd10149}, {14'd8923, 14'd9420, 14'd10149},
		{14'd8753, 14'd9316, 14'd10149}, {14'd8591, 14'd9215, 14'd10149},
		{14'd8437, 14'd9120, 14'd10149}, {14'd8289, 14'd9028, 14'd10149},
		{14'd8149, 14'd8939, 14'd10149}, {14'd8014, 14'd8854, 14'd10149},
		{14'd7885, 14'd8772, 14'd10149}, {14'd7762, 14'd8693, 14'd10149},
		{14'd7644, 14'd8617, 14'd10149}, {14'd7531, 14'd8543, 14'd10149},
		{14'd7423, 14'd8472, 14'd10149}, {14'd7319, 14'd8404, 14'd10149},
		{14'd7219, 14'd8338, 14'd10149}, {14'd7123, 14'd8274, 14'd10149},
		{14'd7030, 14'd8213, 14'd10149}, {14'd6941, 14'd8152, 14'd10149},
		{14'd6856, 14'd8094, 14'd10149}, {14'd6773, 14'd8039, 14'd10149},
		{14'd6693, 14'd7984, 14'd10149}, {14'd6617, 14'd7932, 14'd10149},
		{14'd6543, 14'd7881, 14'd10149}, {14'd6471, 14'd7832, 14'd10149},
		{14'd6402, 14'd7784, 14'd10149}, {14'd6335, 14'd7737, 14'd10149},
		{14'd6271, 14'd7692, 14'd10149}, {14'd6208, 14'd7648, 14'd10149},
		{14'd6148, 14'd7605, 14'd10149}, {14'd6089, 14'd7564, 14'd10149},
		{14'd6033, 14'd7524, 14'd10149}
	};

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem_v;
		logic [63:0] res;
		logic [63:0] bit_v;
		rem_v = v;
		res = '0;
		bit_v = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem_v >= res + bit_v) begin
				rem_v = rem_v - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-j) with 30 fraction bits, each a floor square root of the one before.
	function automatic logic [29:0] exp_factor(input int unsigned j);
		logic [63:0] c;
		c = 64'h2000_0000;
		for (int unsigned i = 1; i <= j; i++) begin
			c = isqrt64(c << 30);
		end
		return c[29:0];
	endfunction

endpackage

// ----- sv/grwp_idx_if.sv -----
// ----------------------------------------------------------------------------
// Ramp index channel
// Valid/ready channel that carries one ramp index per transfer.
// ----------------------------------------------------------------------------
interface grwp_idx_if
	import grwp_pkg::*;
();
	logic valid;
	logic ready;
	logic [IDX_W-1:0] ramp_index;

	modport source(output valid, output ramp_index, input ready);
	modport sink(input valid, input ramp_index, output ready);
endinterface

// ----- sv/grwp_lvl_if.sv -----
// ----------------------------------------------------------------------------
// Ramp level channel
// Valid/ready channel that carries the red, green and blue ramp words.
// ----------------------------------------------------------------------------
interface grwp_lvl_if
	import grwp_pkg::*;
();
	logic valid;
	logic ready;
	logic [LVL_W-1:0] red_level;
	logic [LVL_W-1:0] green_level;
	logic [LVL_W-1:0] blue_level;

	modport source(output valid, output red_level, output green_level, output blue_level,
		input ready);
	modport sink(input valid, input red_level, input green_level, input blue_level,
		output ready);
endinterface

// ----- sv/gamma_ramp_white_point_top.sv -----
// ----------------------------------------------------------------------------
// Gamma ramp generator with blackbody white point
// Turns a ramp index into red, green and blue gamma ramp words.
// ----------------------------------------------------------------------------
// The block takes one ramp index per cycle while its results are taken and returns
// its three ramp words, one transfer per cycle in a sustained burst. The pipeline is
// built from two chains of 16 dependent multiplies each: the squaring steps of the base-2
// logarithm and the product of the exponent factors, one multiply per stage,
// plus seven stages of a three-bit-per-stage divider by the channel gamma. The
// whole pipeline holds while a finished result is not taken. The white point is
// derived from the temperature register in a separate registered path.
module gamma_ramp_white_point_top
	import grwp_pkg::*;
#(
	parameter int unsigned MAX_RAMP_LENGTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	grwp_idx_if.sink          idx_ch,
	grwp_lvl_if.source        lvl_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam logic [16:0] MAX_LEN = 17'(MAX_RAMP_LENGTH);
	localparam int unsigned ST_LOGN = LOG_BITS + 1;
	localparam int unsigned ST_D = ST_LOGN + 1;
	localparam int unsigned ST_DIVN = ST_D + DIV_STAGES;
	localparam int unsigned ST_EXP1 = ST_DIVN + 1;
	localparam int unsigned ST_EXPN = ST_DIVN + EXP_BITS;
	localparam int unsigned ST_P = ST_EXPN + 1;
	localparam int unsigned ST_M = ST_P + 1;
	localparam int unsigned ST_O = ST_M + 1;

	typedef struct packed {
		logic zero;
		logic full;
	} flg_t;

	typedef struct packed {
		logic [3:0]  e;
		logic [30:0] m;
		logic [15:0] fr;
	} lg_t;

	typedef struct packed {
		logic        ovf;
		logic [11:0] rem;
		logic [20:0] num;
		logic [20:0] quo;
	} dv_t;

	typedef struct packed {
		logic        pz;
		logic [4:0]  k;
		logic [15:0] fr;
		logic [30:0] r;
	} ex_t;

	function automatic lg_t log_init(input logic [LEN_W-1:0] n);
		lg_t o;
		logic [42:0] w;
		o.e = '0;
		for (int i = 0; i < LEN_W; i++) begin
			if (n[i]) begin
				o.e = 4'(i);
			end
		end
		w = {n, 30'b0} >> o.e;
		o.m = w[30:0];
		o.fr = '0;
		return o;
	endfunction

	function automatic lg_t log_step(input lg_t a);
		lg_t o;
		logic [61:0] sq;
		logic [31:0] t;
		sq = {31'b0, a.m} * {31'b0, a.m};
		t = sq[61:30];
		o.e = a.e;
		if (t[31]) begin
			o.m = t[31:1];
			o.fr = {a.fr[14:0], 1'b1};
		end else begin
			o.m = t[30:0];
			o.fr = {a.fr[14:0], 1'b0};
		end
		return o;
	endfunction

	function automatic dv_t div_step(input dv_t a, input logic [GAM_W-1:0] g);
		dv_t o;
		logic [12:0] trial;
		logic [12:0] diff;
		o = a;
		for (int i = 0; i < DIV_PER_STAGE; i++) begin
			trial = {o.rem, o.num[20]};
			diff = trial - {1'b0, g};
			o.num = {o.num[19:0], 1'b0};
			if (trial >= {1'b0, g}) begin
				o.rem = diff[11:0];
				o.quo = {o.quo[19:0], 1'b1};
			end else begin
				o.rem = trial[11:0];
				o.quo = {o.quo[19:0], 1'b0};
			end
		end
		return o;
	endfunction

	function automatic ex_t ex_init(input dv_t a);
		ex_t o;
		o.k = a.quo[20:16];
		o.pz = a.ovf | (o.k >= K_LIMIT);
		o.fr = a.quo[15:0];
		o.r = 31'h4000_0000;
		return o;
	endfunction

	function automatic ex_t ex_step(input ex_t a, input logic [29:0] c, input logic b);
		ex_t o;
		logic [60:0] pr;
		o = a;
		pr = {30'b0, a.r} * {31'b0, c};
		if (b) begin
			o.r = pr[60:30];
		end
		return o;
	endfunction

	// Configuration registers.
	logic [TEMP_W-1:0] temp_q;
	logic [GAM_W-1:0]  gam_q [3];
	logic [LEN_W-1:0]  len_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= 14'd6500;
			gam_q[0] <= 12'd256;
			gam_q[1] <= 12'd256;
			gam_q[2] <= 12'd256;
			len_q <= 13'd256;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_TEMP: temp_q <= pwdata[TEMP_W-1:0];
				REG_GAM_R: gam_q[0] <= pwdata[GAM_W-1:0];
				REG_GAM_G: gam_q[1] <= pwdata[GAM_W-1:0];
				REG_GAM_B: gam_q[2] <= pwdata[GAM_W-1:0];
				REG_LEN: len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_TEMP: prdata = APB_DW'(temp_q);
			REG_GAM_R: prdata = APB_DW'(gam_q[0]);
			REG_GAM_G: prdata = APB_DW'(gam_q[1]);
			REG_GAM_B: prdata = APB_DW'(gam_q[2]);
			REG_LEN: prdata = APB_DW'(len_q);
			default: prdata = '0;
		endcase
	end

	logic [GAM_W-1:0] gam_eff [3];
	logic [LEN_W-1:0] len_eff;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			gam_eff[ch] = (gam_q[ch] == '0) ? 12'd1 : gam_q[ch];
		end
		len_eff = (len_q == '0) ? 13'd1 : len_q;
		if ({4'b0, len_eff} > MAX_LEN) begin
			len_eff = MAX_LEN[LEN_W-1:0];
		end
	end

	// White point path, which settles through its registers after a temperature write.
	logic [13:0] tk_c;
	logic [13:0] tx_c;
	logic [26:0] rprod_c;
	logic [13:0] tx_q;
	logic [6:0]  row_q;
	logic [6:0]  nxt_c;
	logic [13:0] fsub_c;
	logic [6:0]  f_q;
	logic [41:0] crow_q;
	logic [41:0] cnxt_q;
	logic [19:0] s_q [3];
	logic [16:0] white_q [3];

	always_comb begin
		if (temp_q < T_MIN) begin
			tk_c = T_MIN;
		end else if (temp_q > T_MAX) begin
			tk_c = T_MAX;
		end else begin
			tk_c = temp_q;
		end
		tx_c = tk_c - T_MIN;
		rprod_c = {13'b0, tx_c} * {14'b0, ROW_RECIP};
		nxt_c = (row_q >= ROM_LAST) ? ROM_LAST : row_q + 7'd1;
		fsub_c = tx_q - 14'(row_q) * 14'(T_STEP);
	end

	always_ff @(posedge clk) begin
		tx_q <= tx_c;
		row_q <= rprod_c[ROW_SHIFT +: 7];
		f_q <= fsub_c[6:0];
		crow_q <= BB_ROM[row_q];
		cnxt_q <= BB_ROM[nxt_c];
		for (int ch = 0; ch < 3; ch++) begin
			s_q[ch] <= 20'(T_STEP - f_q) * 20'(crow_q[14*(2-ch) +: 14]) +
				20'(f_q) * 20'(cnxt_q[14*(2-ch) +: 14]);
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_white
		logic [50:0] wprod;
		assign wprod = 51'(s_q[ch]) * 51'(WP_RECIP);
		always_ff @(posedge clk) begin
			white_q[ch] <= wprod[WP_SHIFT +: 17];
		end
	end

	// Item pipeline.
	logic adv;
	logic vld_s [1:ST_O];
	flg_t flg_s [1:ST_O];
	lg_t  lgi_s [1:ST_LOGN];
	lg_t  lgl_s [1:ST_LOGN];
	dv_t  dv_s [ST_D:ST_DIVN][3];
	ex_t  ex_s [ST_EXP1:ST_EXPN][3];
	logic [16:0] p_s42 [3];
	logic [33:0] x_s43 [3];
	logic [LVL_W-1:0] lvl_s44 [3];

	assign adv = !vld_s[ST_O] || lvl_ch.ready;
	assign idx_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ST_O; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= idx_ch.valid;
			for (int i = 2; i <= ST_O; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flg_s[1].zero <= (idx_ch.ramp_index == '0);
			flg_s[1].full <= ({1'b0, idx_ch.ramp_index} >= len_eff);
			for (int i = 2; i <= ST_O; i++) begin
				flg_s[i] <= flg_s[i-1];
			end
			lgi_s[1] <= log_init({1'b0, idx_ch.ramp_index});
			lgl_s[1] <= log_init(len_eff);
		end
	end

	for (genvar j = 2; j <= ST_LOGN; j++) begin : g_log
		always_ff @(posedge clk) begin
			if (adv) begin
				lgi_s[j] <= log_step(lgi_s[j-1]);
				lgl_s[j] <= log_step(lgl_s[j-1]);
			end
		end
	end

	logic [19:0] ls_c;
	logic [19:0] li_c;
	logic [27:0] dnum_c;

	always_comb begin
		ls_c = {lgl_s[ST_LOGN].e, lgl_s[ST_LOGN].fr};
		li_c = {lgi_s[ST_LOGN].e, lgi_s[ST_LOGN].fr};
		dnum_c = (ls_c > li_c) ? {ls_c - li_c, 8'b0} : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				dv_s[ST_D][ch].ovf <= ({5'b0, dnum_c[27:21]} >= gam_eff[ch]);
				dv_s[ST_D][ch].rem <= ({5'b0, dnum_c[27:21]} >= gam_eff[ch]) ?
					'0 : {5'b0, dnum_c[27:21]};
				dv_s[ST_D][ch].num <= dnum_c[20:0];
				dv_s[ST_D][ch].quo <= '0;
			end
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int ch = 0; ch < 3; ch++) begin
					dv_s[ST_D+k][ch] <= div_step(dv_s[ST_D+k-1][ch], gam_eff[ch]);
				end
			end
		end
	end

	for (genvar j = 1; j <= EXP_BITS; j++) begin : g_exp
		localparam logic [29:0] FACTOR = exp_factor(j);
		if (j == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int ch = 0; ch < 3; ch++) begin
						ex_s[ST_EXP1][ch] <= ex_step(ex_init(dv_s[ST_DIVN][ch]), FACTOR,
							dv_s[ST_DIVN][ch].quo[EXP_BITS-1]);
					end
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int ch = 0; ch < 3; ch++) begin
						ex_s[ST_EXP1+j-1][ch] <= ex_step(ex_s[ST_EXP1+j-2][ch], FACTOR,
							ex_s[ST_EXP1+j-2][ch].fr[EXP_BITS-j]);
					end
				end
			end
		end
	end

	logic [30:0] rs_c [3];
	logic [49:0] y_c [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			rs_c[ch] = ex_s[ST_EXPN][ch].r >> (EXP_SHIFT + ex_s[ST_EXPN][ch].k);
			y_c[ch] = {x_s43[ch], 16'b0} - {16'b0, x_s43[ch]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (flg_s[ST_EXPN].zero) begin
					p_s42[ch] <= '0;
				end else if (flg_s[ST_EXPN].full) begin
					p_s42[ch] <= P_ONE;
				end else if (ex_s[ST_EXPN][ch].pz) begin
					p_s42[ch] <= '0;
				end else begin
					p_s42[ch] <= rs_c[ch][16:0];
				end
				x_s43[ch] <= {17'b0, p_s42[ch]} * {17'b0, white_q[ch]};
				lvl_s44[ch] <= (y_c[ch][49:48] != 2'b00) ? LEVEL_MAX : y_c[ch][47:32];
			end
		end
	end

	assign lvl_ch.valid = vld_s[ST_O];
	assign lvl_ch.red_level = lvl_s44[0];
	assign lvl_ch.green_level = lvl_s44[1];
	assign lvl_ch.blue_level = lvl_s44[2];

endmodule

// ----- sv/grwp_checker.sv -----
// ----------------------------------------------------------------------------
// Gamma ramp white point checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module grwp_checker
	import grwp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              idx_ready,
	input logic              lvl_valid,
	input logic              lvl_ready,
	input logic [LVL_W-1:0]  red_level,
	input logic [LVL_W-1:0]  green_level,
	input logic [LVL_W-1:0]  blue_level,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic              pready,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic [APB_DW-1:0] prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_valid && !lvl_ready |=> lvl_valid && $stable(red_level) &&
		$stable(green_level) && $stable(blue_level))
		else $error("Stalled result transfer changed or was dropped.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!lvl_valid |-> idx_ready)
		else $error("Input not ready although no result is waiting.");

	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !lvl_valid)
		else $error("Result valid right after reset.");

	a_gamma_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[4:2] == REG_GAM_R |=>
		(!(psel && !pwrite && paddr[4:2] == REG_GAM_R) ||
		prdata == {20'b0, $past(pwdata[GAM_W-1:0])}))
		else $error("Red gamma register read back a wrong value.");

endmodule

bind gamma_ramp_white_point_top grwp_checker u_grwp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.idx_ready(idx_ch.ready),
	.lvl_valid(lvl_ch.valid),
	.lvl_ready(lvl_ch.ready),
	.red_level(lvl_ch.red_level),
	.green_level(lvl_ch.green_level),
	.blue_level(lvl_ch.blue_level),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.pready(pready),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);
